// File: design/kte_pkg.sv
// ----------------------------------------------------------------------------
// kte_pkg: shared types and constants of the keyframe tick timestamp extender
// Request payloads, the front-to-back queue entry and protocol constants.
// ----------------------------------------------------------------------------
`default_nettype none

package kte_pkg;

    // Incoming packet request, one pre-parsed packet
    typedef struct packed {
        logic [1:0]  frame_class;
        logic [7:0]  ip_protocol;
        logic [15:0] ip_total_length;
        logic [31:0] dest_address;
        logic [31:0] footer_word;
        logic [63:0] key_utc_time;
        logic [63:0] key_asic_tick;
        logic [63:0] key_egress_tick;
        logic [63:0] capture_time;
    } packet_t;

    // Outgoing result request
    typedef struct packed {
        logic [63:0] timestamp;
        logic        timestamp_valid;
        logic        is_keyframe;
        logic        keyframe_length_error;
        logic [1:0]  time_source;
    } result_t;

    // Classified packet handed from the front end to the arithmetic pipe
    typedef struct packed {
        logic [63:0] utc;       // keyframe UTC after this packet
        logic [63:0] rtick;     // keyframe tick after this packet
        logic [63:0] egress;    // egress tick, zero unless a good keyframe
        logic [31:0] tick32;    // extended footer tick
        logic [63:0] cap;       // capture time
        logic        use_cap;
        logic        key;
        logic        len_err;
        logic        ts_valid;
    } front_item_t;

    // Frame classes
    localparam logic [1:0] CLASS_IPV4 = 2'd1;
    localparam logic [1:0] CLASS_STP  = 2'd2;

    // Time source codes
    localparam logic [1:0] SRC_TICK    = 2'd0;
    localparam logic [1:0] SRC_EGRESS  = 2'd1;
    localparam logic [1:0] SRC_CAPTURE = 2'd2;

    // Keyframe recognition
    localparam logic [7:0]  KEY_PROTOCOL  = 8'd253;
    localparam logic [15:0] KEY_LEN_PLAIN = 16'd66;
    localparam logic [15:0] KEY_LEN_SKEW  = 16'd82;

    // PTP multicast 224.0.1.129 .. 224.0.1.132
    localparam logic [23:0] PTP_PREFIX = 24'hE00001;
    localparam logic [7:0]  PTP_LO_MIN = 8'd129;
    localparam logic [7:0]  PTP_LO_MAX = 8'd132;

    // Upper part of the reference tick kept on the tick path
    localparam logic [63:0] TICK_HI_MASK = 64'hFFFF_FFFF_8000_0000;

    // Default queue depths
    localparam int MID_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 4;

endpackage

`default_nettype wire

// File: design/kte_fifo.sv
// ----------------------------------------------------------------------------
// kte_fifo: small register queue
// Flip-flop storage, head visible combinationally, write ignored when full.
// ----------------------------------------------------------------------------
`default_nettype none

module kte_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             rd,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem_reg[rd_ptr_reg];

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// File: design/kte_front.sv
// ----------------------------------------------------------------------------
// kte_front: packet classifier and keyframe reference state
// Classifies each request, reloads the reference on good keyframes and
// extends the footer tick against the stored low bits.
// ----------------------------------------------------------------------------
`default_nettype none

module kte_front
    import kte_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    accept,
    input  wire packet_t packet,
    output front_item_t  item
);

    logic [63:0] ref_utc_reg;
    logic [63:0] ref_tick_reg;
    logic [30:0] ref_low_reg;

    logic [63:0] utc_next;
    logic [63:0] tick_next;
    logic [30:0] low_next;
    logic [30:0] tick31;
    logic [31:0] tick_ext;
    logic        is_ip;
    logic        key;
    logic        good_len;
    logic        reload;
    logic        ptp;

    // Classification
    always_comb
    begin
        is_ip    = (packet.frame_class == CLASS_IPV4);
        key      = is_ip && (packet.ip_protocol == KEY_PROTOCOL);
        good_len = (packet.ip_total_length inside {KEY_LEN_PLAIN, KEY_LEN_SKEW});
        reload   = key && good_len;
        ptp      = is_ip && (packet.dest_address[31:8] == PTP_PREFIX)
                   && (packet.dest_address[7:0] inside {[PTP_LO_MIN:PTP_LO_MAX]});
    end

    // Reference after this packet
    always_comb
    begin
        utc_next  = reload ? packet.key_utc_time  : ref_utc_reg;
        tick_next = reload ? packet.key_asic_tick : ref_tick_reg;
        low_next  = reload ? packet.key_asic_tick[30:0] : ref_low_reg;
    end

    // Footer tick: drop the pad bit, carry by 2^31 below the stored low bits
    always_comb
    begin
        tick31   = {packet.footer_word[31:8], packet.footer_word[6:0]};
        tick_ext = {(tick31 < ref_low_reg), tick31};
    end

    // Queue entry
    always_comb
    begin
        item.utc      = utc_next;
        item.rtick    = tick_next;
        item.egress   = reload ? packet.key_egress_tick : 64'd0;
        item.tick32   = key ? {1'b0, low_next} : tick_ext;
        item.cap      = packet.capture_time;
        item.use_cap  = ptp || (packet.frame_class == CLASS_STP) || (utc_next == 64'd0);
        item.key      = key;
        item.len_err  = key && !good_len;
        item.ts_valid = (utc_next != 64'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_utc_reg  <= '0;
            ref_tick_reg <= '0;
            ref_low_reg  <= '0;
        end
        else if (accept && reload)
        begin
            ref_utc_reg  <= utc_next;
            ref_tick_reg <= tick_next;
            ref_low_reg  <= low_next;
        end
    end

endmodule

`default_nettype wire

// File: design/kte_back.sv
// ----------------------------------------------------------------------------
// kte_back: tick to nanosecond arithmetic pipe
// Twelve stages: tick join, difference, scale by 20, eight divide-by-7
// stages of eight bits each, UTC add; final source selection.
// ----------------------------------------------------------------------------
`default_nettype none

module kte_back
    import kte_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire front_item_t head,
    input  wire logic        mid_empty,
    output logic             mid_pop,
    input  wire logic        out_full,
    output logic             out_wr,
    output result_t          out_data
);

    localparam int S_DIFF      = 1;
    localparam int S_SCALE     = 2;
    localparam int S_SUM       = 11;
    localparam int NUM_STAGES  = 12;
    localparam int LAST        = NUM_STAGES - 1;

    typedef struct packed {
        logic [63:0] utc;
        logic [63:0] cap;
        logic [63:0] rtick;
        logic [63:0] na;    // egress path operand
        logic [63:0] nb;    // tick path operand
        logic [63:0] qa;
        logic [63:0] qb;
        logic [2:0]  ra;
        logic [2:0]  rb;
        logic        use_cap;
        logic        key;
        logic        len_err;
        logic        ts_valid;
    } back_stage_t;

    // x * 20 modulo 2^64
    function automatic logic [63:0] times20(input logic [63:0] x);
        return (x << 4) + (x << 2);
    endfunction

    // Eight bits of long division by 7: {quotient bits, remainder}
    function automatic logic [10:0] div7_step(input logic [2:0] rem_in,
                                              input logic [7:0] bits);
        logic [3:0] r;
        logic [7:0] q;
        r = {1'b0, rem_in};
        q = '0;
        for (int i = 7; i >= 0; i--)
        begin
            r = {r[2:0], bits[i]};
            if (r >= 4'd7)
            begin
                q[i] = 1'b1;
                r    = r - 4'd7;
            end
        end
        return {q, r[2:0]};
    endfunction

    back_stage_t stage_reg  [NUM_STAGES];
    back_stage_t stage_next [NUM_STAGES];
    logic        vld_reg    [NUM_STAGES];
    logic        en;
    back_stage_t last;
    logic [63:0] primary;
    logic [1:0]  src;

    // Pipe advances unless a finished request is blocked at the end
    assign en      = !vld_reg[LAST] || !out_full;
    assign mid_pop = en && !mid_empty;
    assign out_wr  = en && vld_reg[LAST];

    // Stage operations
    always_comb
    begin
        back_stage_t s;
        logic [10:0] sa;
        logic [10:0] sb;

        // join the footer tick to the reference upper bits
        s          = '0;
        s.utc      = head.utc;
        s.cap      = head.cap;
        s.rtick    = head.rtick;
        s.na       = head.egress - head.rtick;
        s.nb       = (head.rtick & TICK_HI_MASK) + {32'd0, head.tick32};
        s.use_cap  = head.use_cap;
        s.key      = head.key;
        s.len_err  = head.len_err;
        s.ts_valid = head.ts_valid;
        stage_next[0] = s;

        for (int k = 1; k < NUM_STAGES; k++)
        begin
            s  = stage_reg[k-1];
            sa = '0;
            sb = '0;
            if (k == S_DIFF)
            begin
                s.nb = s.nb - s.rtick;
            end
            else if (k == S_SCALE)
            begin
                s.na = times20(s.na);
                s.nb = times20(s.nb);
                s.qa = '0;
                s.qb = '0;
                s.ra = '0;
                s.rb = '0;
            end
            else if (k < S_SUM)
            begin
                // one byte of each dividend per stage, top first
                sa   = div7_step(s.ra, s.na[63:56]);
                sb   = div7_step(s.rb, s.nb[63:56]);
                s.qa = {s.qa[55:0], sa[10:3]};
                s.qb = {s.qb[55:0], sb[10:3]};
                s.ra = sa[2:0];
                s.rb = sb[2:0];
                s.na = {s.na[55:0], 8'd0};
                s.nb = {s.nb[55:0], 8'd0};
            end
            else
            begin
                s.na = s.utc + s.qa;
                s.nb = s.utc + s.qb;
            end
            stage_next[k] = s;
        end
    end

    // Source selection, falling back to the tick path on a zero value
    always_comb
    begin
        last = stage_reg[LAST];
        if (last.use_cap)
        begin
            primary = last.cap;
            src     = SRC_CAPTURE;
        end
        else if (last.key)
        begin
            primary = last.na;
            src     = SRC_EGRESS;
        end
        else
        begin
            primary = 64'd0;
            src     = SRC_TICK;
        end
        out_data.timestamp             = primary;
        out_data.time_source           = src;
        if (primary == 64'd0)
        begin
            out_data.timestamp   = last.nb;
            out_data.time_source = SRC_TICK;
        end
        out_data.timestamp_valid       = last.ts_valid;
        out_data.is_keyframe           = last.key;
        out_data.keyframe_length_error = last.len_err;
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_STAGES; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= !mid_empty;
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Stage data, no reset
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NUM_STAGES; k++)
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

endmodule

`default_nettype wire

// File: design/keyframe_tick_timestamp_extender_top.sv
// Path: an accepted packet goes through the middle queue and the arithmetic pipe
//   into the result queue.
// Throughput: one packet per cycle unless a full queue stalls, set by the
//   twelve-stage arithmetic pipe and the keyframe state update in the front end.
// Reset: clears the keyframe reference to zero (no keyframe) and empties
//   both queues and the pipe.
// ----------------------------------------------------------------------------
// keyframe_tick_timestamp_extender_top: packet timestamp extender
// Front end classifies and tracks keyframes, a queue decouples it from the
// arithmetic pipe, which feeds the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_tick_timestamp_extender_top
    import kte_pkg::*;
#(
    parameter int MID_DEPTH = MID_DEPTH_DEF,
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    output logic         full,
    input  wire packet_t packet,
    output logic         empty,
    input  wire logic    pop,
    output result_t      result
);

    localparam int ITEM_W = $bits(front_item_t);
    localparam int RES_W  = $bits(result_t);

    front_item_t      front_item;
    logic [ITEM_W-1:0] head_bits;
    front_item_t      head;
    logic             accept;
    logic             mid_empty;
    logic             mid_pop;
    logic             out_full;
    logic             out_wr;
    result_t          out_data;
    logic [RES_W-1:0] res_bits;

    assign accept = push && !full;

    // Classification and keyframe state
    kte_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .packet (packet),
        .item   (front_item)
    );

    // Queue between front end and pipe
    kte_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (accept),
        .wdata (front_item),
        .full  (full),
        .rd    (mid_pop),
        .rdata (head_bits),
        .empty (mid_empty)
    );

    assign head = front_item_t'(head_bits);

    // Arithmetic pipe
    kte_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .mid_empty (mid_empty),
        .mid_pop   (mid_pop),
        .out_full  (out_full),
        .out_wr    (out_wr),
        .out_data  (out_data)
    );

    // Result queue
    kte_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (out_wr),
        .wdata (out_data),
        .full  (out_full),
        .rd    (pop),
        .rdata (res_bits),
        .empty (empty)
    );

    assign result = result_t'(res_bits);

endmodule

`default_nettype wire

// File: design/kte_checker.sv
// ----------------------------------------------------------------------------
// kte_checker: port-level checks of the timestamp extender
// Consistency of result flags and stability of a waiting result.
// ----------------------------------------------------------------------------
`default_nettype none

module kte_checker
    import kte_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    empty,
    input wire logic    pop,
    input wire result_t result
);

    // A length error only comes with a keyframe
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (!result.keyframe_length_error || result.is_keyframe))
        else $error("length error on a non-keyframe result");

    // Egress timing needs a keyframe and a valid reference
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.time_source == SRC_EGRESS)
            |-> (result.is_keyframe && result.timestamp_valid))
        else $error("egress source without keyframe reference");

    // Only three time source codes exist
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.time_source == SRC_TICK || result.time_source == SRC_EGRESS
                    || result.time_source == SRC_CAPTURE))
        else $error("unknown time source code");

    // A waiting result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed or vanished");

endmodule

bind keyframe_tick_timestamp_extender_top kte_checker u_kte_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

`default_nettype wire

// File: dv/keyframe_tick_timestamp_extender_checker.sv
// ----------------------------------------------------------------------------
// keyframe_tick_timestamp_extender_checker: result checker for the extender
// Watches both queue handshakes and keeps its own copy of the keyframe
// reference. Each accepted packet request gets a predicted timestamp. Each
// popped result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module keyframe_tick_timestamp_extender_checker
    import kte_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  logic    full,
    input  packet_t packet,
    input  logic    empty,
    input  logic    pop,
    input  result_t result,
    output int      mismatches,
    output int      pending
);

    // Keyframe reference as the block should hold it
    logic [63:0] anchor_utc;
    logic [63:0] anchor_tick;
    logic [30:0] anchor_low;

    // Predicted results, oldest first
    result_t stamp_queue[$];

    // Tick difference to ns: times 20 (wrapping at 64 bits), then over 7
    function automatic logic [63:0] ticks_to_ns(input logic [63:0] ticks);
        logic [63:0] scaled;
        scaled = ticks * 64'd20;
        return scaled / 64'd7;
    endfunction

    // Works out the result of one packet and moves the reference along
    function automatic result_t stamp_packet(input packet_t p);
        result_t     r;
        logic [31:0] tick_ext;
        logic [63:0] egress;
        logic [63:0] ts;
        logic [63:0] tick_full;
        logic [1:0]  src;
        logic        key;
        logic        len_err;
        // footer bit 7 is padding
        tick_ext = {1'b0, p.footer_word[31:8], p.footer_word[6:0]};
        ts       = '0;
        egress   = '0;
        src      = SRC_TICK;
        key      = 1'b0;
        len_err  = 1'b0;

        // Below the stored low part means the footer tick has wrapped
        if (tick_ext < {1'b0, anchor_low})
            tick_ext = tick_ext + 32'h8000_0000;

        if (p.frame_class == CLASS_IPV4)
        begin
            // Keyframe: reload on a good length, else egress counts as zero
            if (p.ip_protocol == KEY_PROTOCOL)
            begin
                key = 1'b1;
                if (p.ip_total_length == KEY_LEN_PLAIN || p.ip_total_length == KEY_LEN_SKEW)
                begin
                    anchor_utc  = p.key_utc_time;
                    anchor_tick = p.key_asic_tick;
                    anchor_low  = p.key_asic_tick[30:0];
                    egress      = p.key_egress_tick;
                end
                else
                begin
                    len_err = 1'b1;
                end
                tick_ext = {1'b0, anchor_low};
                ts       = anchor_utc + ticks_to_ns(egress - anchor_tick);
                src      = SRC_EGRESS;
            end
            // PTP multicast keeps the capture time
            if (p.dest_address[31:8] == PTP_PREFIX &&
                p.dest_address[7:0] >= PTP_LO_MIN && p.dest_address[7:0] <= PTP_LO_MAX)
            begin
                ts  = p.capture_time;
                src = SRC_CAPTURE;
            end
        end

        if (p.frame_class == CLASS_STP)
        begin
            ts  = p.capture_time;
            src = SRC_CAPTURE;
        end

        // No keyframe reference yet
        if (anchor_utc == '0)
        begin
            ts  = p.capture_time;
            src = SRC_CAPTURE;
        end

        // A zero value falls back to the extended footer tick
        if (ts == '0)
        begin
            tick_full = (anchor_tick & TICK_HI_MASK) + {32'b0, tick_ext};
            ts        = anchor_utc + ticks_to_ns(tick_full - anchor_tick);
            src       = SRC_TICK;
        end

        r.timestamp             = ts;
        r.timestamp_valid       = (anchor_utc != '0);
        r.is_keyframe           = key;
        r.keyframe_length_error = len_err;
        r.time_source           = src;
        return r;
    endfunction

    function automatic int field_diff(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Compare popped results, then predict newly pushed requests
    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t want;
        int      errs;
        if (!rst_n)
        begin
            anchor_utc  = '0;
            anchor_tick = '0;
            anchor_low  = '0;
            stamp_queue.delete();
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            errs = 0;
            if (pop && !empty)
            begin
                if (stamp_queue.size() == 0)
                begin
                    $display("%0t: result with no request waiting, expected none, actual %h",
                             $time, result);
                    errs++;
                end
                else
                begin
                    want = stamp_queue.pop_front();
                    errs += field_diff("timestamp", want.timestamp, result.timestamp);
                    errs += field_diff("timestamp_valid", 64'(want.timestamp_valid),
                                       64'(result.timestamp_valid));
                    errs += field_diff("is_keyframe", 64'(want.is_keyframe),
                                       64'(result.is_keyframe));
                    errs += field_diff("keyframe_length_error",
                                       64'(want.keyframe_length_error),
                                       64'(result.keyframe_length_error));
                    errs += field_diff("time_source", 64'(want.time_source),
                                       64'(result.time_source));
                end
            end
            if (push && !full)
                stamp_queue.push_back(stamp_packet(packet));
            mismatches <= mismatches + errs;
            pending    <= stamp_queue.size();
        end
    end

endmodule

// File: dv/keyframe_tick_timestamp_extender_top_test.sv
// ----------------------------------------------------------------------------
// keyframe_tick_timestamp_extender_top_test: testbench for the extender
// Sends a directed set of packets covering keyframes, length errors, PTP,
// STP, tick wrap and zero-value fallback, then random keyframe-anchored
// traffic with bursty pushes and patterned pops. The checker does the rest.
// ----------------------------------------------------------------------------
module keyframe_tick_timestamp_extender_top_test;
    import kte_pkg::*;

    localparam int RANDOM_PACKETS = 1625;
    localparam int IDLE_LIMIT     = 2000;
    localparam int HOLD_CYCLES    = 150;
    localparam int HOLD_AFTER     = 500;
    localparam int DRAIN_CYCLES   = 30;

    typedef enum int {POP_ALWAYS, POP_HALF, POP_MOSTLY, POP_SPARSE} pop_mode_t;

    logic    clk;
    logic    rst_n  = 1'b0;
    logic    push   = 1'b0;
    logic    pop    = 1'b0;
    packet_t packet = '0;
    logic    full;
    logic    empty;
    result_t result;
    int      mismatches;
    int      pending;

    // Sender burst state and the keyframe low tick the traffic aims at
    int          burst_left = 0;
    logic [30:0] aim_low    = '0;

    keyframe_tick_timestamp_extender_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .packet (packet),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    keyframe_tick_timestamp_extender_checker stamp_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .packet     (packet),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Footer word carrying a 31-bit tick, pad bit 7 random
    function automatic logic [31:0] footer_for_tick(input logic [30:0] t);
        logic pad;
        pad = 1'($urandom_range(0, 1));
        return {t[30:7], pad, t[6:0]};
    endfunction

    function automatic packet_t make_pkt(input logic [1:0] cls, input logic [7:0] proto,
                                         input logic [15:0] len, input logic [31:0] dst,
                                         input logic [31:0] foot, input logic [63:0] utc,
                                         input logic [63:0] tick, input logic [63:0] egress,
                                         input logic [63:0] cap);
        packet_t p;
        p.frame_class     = cls;
        p.ip_protocol     = proto;
        p.ip_total_length = len;
        p.dest_address    = dst;
        p.footer_word     = foot;
        p.key_utc_time    = utc;
        p.key_asic_tick   = tick;
        p.key_egress_tick = egress;
        p.capture_time    = cap;
        return p;
    endfunction

    // Mostly keyframes and data near the last keyframe tick, some noise
    function automatic packet_t random_packet();
        packet_t     p;
        int          pick;
        logic [30:0] t;
        p.frame_class     = 2'($urandom);
        p.ip_protocol     = 8'($urandom);
        p.ip_total_length = 16'($urandom);
        p.dest_address    = $urandom();
        p.footer_word     = $urandom();
        p.key_utc_time    = rand64();
        p.key_asic_tick   = rand64();
        p.key_egress_tick = rand64();
        p.capture_time    = ($urandom_range(0, 19) == 0) ? 64'd0 : rand64();
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            // good keyframe
            p.frame_class     = CLASS_IPV4;
            p.ip_protocol     = KEY_PROTOCOL;
            p.ip_total_length = $urandom_range(0, 1) ? KEY_LEN_PLAIN : KEY_LEN_SKEW;
            if ($urandom_range(0, 15) == 0)
                p.key_utc_time = '0;
            if ($urandom_range(0, 3) != 0)
                p.key_egress_tick = p.key_asic_tick + 64'($urandom_range(0, 200000));
            if ($urandom_range(0, 7) == 0)
                p.dest_address = {PTP_PREFIX, 8'($urandom_range(127, 134))};
            aim_low = p.key_asic_tick[30:0];
        end
        else if (pick < 11)
        begin
            // keyframe with a bad length
            p.frame_class = CLASS_IPV4;
            p.ip_protocol = KEY_PROTOCOL;
            if (p.ip_total_length == KEY_LEN_PLAIN || p.ip_total_length == KEY_LEN_SKEW)
                p.ip_total_length = p.ip_total_length + 16'd1;
        end
        else if (pick < 70)
        begin
            // data packet, tick a little ahead of (or just behind) the keyframe
            p.frame_class = CLASS_IPV4;
            if (p.ip_protocol == KEY_PROTOCOL)
                p.ip_protocol = 8'd17;
            t = aim_low + 31'($urandom_range(0, 202000)) - 31'd2000;
            if ($urandom_range(0, 7) != 0)
                p.footer_word = footer_for_tick(t);
            if ($urandom_range(0, 15) == 0)
                p.dest_address = {PTP_PREFIX, 8'($urandom_range(127, 134))};
        end
        else if (pick < 77)
        begin
            // PTP multicast and its neighbours
            p.frame_class  = CLASS_IPV4;
            p.dest_address = {PTP_PREFIX, 8'($urandom_range(127, 134))};
            if ($urandom_range(0, 3) == 0)
                p.capture_time = '0;
        end
        else if (pick < 83)
        begin
            p.frame_class = CLASS_STP;
        end
        else if (pick < 89)
        begin
            p.frame_class = $urandom_range(0, 1) ? 2'd3 : 2'd0;
        end
        return p;
    endfunction

    // Offer one request; open a new burst with a random gap when due
    task automatic send_packet(input packet_t p);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        packet <= p;
        push   <= 1'b1;
        do @(posedge clk); while (full);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Stimulus and verdict
    initial
    begin : stimulus
        do @(posedge clk); while (!rst_n);

        // before any keyframe: capture time, then zero capture onto the tick path
        send_packet(make_pkt(CLASS_IPV4, 8'd6, 16'd60, 32'h0A00_0001, 32'h0000_1234,
                             '0, '0, '0, 64'h1234));
        send_packet(make_pkt(CLASS_IPV4, 8'd6, 16'd60, 32'h0A00_0001, 32'hFFFF_FF7F,
                             '0, '0, '0, '0));
        // plain keyframe
        send_packet(make_pkt(CLASS_IPV4, KEY_PROTOCOL, KEY_LEN_PLAIN, 32'h0A00_0002, '0,
                             64'h0000_1000_0000_0000, 64'h0000_0012_3456_7890,
                             64'h0000_0012_3456_7B4C, 64'd5));
        // footer extremes, pad bit only, just ahead of and just behind the keyframe
        send_packet(make_pkt(CLASS_IPV4, 8'd17, 16'd100, 32'h0A00_0003, 32'hFFFF_FFFF,
                             '0, '0, '0, rand64()));
        send_packet(make_pkt(CLASS_IPV4, 8'd17, 16'd100, 32'h0A00_0003, 32'h0000_0000,
                             '1, '1, '1, rand64()));
        send_packet(make_pkt(CLASS_IPV4, 8'd17, 16'd100, 32'h0A00_0003, 32'h0000_0080,
                             '0, '0, '0, rand64()));
        send_packet(make_pkt(CLASS_IPV4, 8'd17, 16'd100, 32'h0A00_0003,
                             footer_for_tick(31'h3456_7895), '0, '0, '0, rand64()));
        send_packet(make_pkt(CLASS_IPV4, 8'd17, 16'd100, 32'h0A00_0003,
                             footer_for_tick(31'h3456_788F), '0, '0, '0, rand64()));
        // keyframe with skew, all-ones fields
        send_packet(make_pkt(CLASS_IPV4, KEY_PROTOCOL, KEY_LEN_SKEW, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF, '1, '1, '1, '1));
        // bad keyframe lengths keep the reference
        send_packet(make_pkt(CLASS_IPV4, KEY_PROTOCOL, 16'd65, 32'h0A00_0004, '0,
                             rand64(), rand64(), rand64(), rand64()));
        send_packet(make_pkt(CLASS_IPV4, KEY_PROTOCOL, 16'hFFFF, 32'h0A00_0004, '0,
                             rand64(), rand64(), rand64(), rand64()));
        // PTP range edges, keyframe to PTP, addresses just outside
        send_packet(make_pkt(CLASS_IPV4, 8'd17, 16'd90, {PTP_PREFIX, PTP_LO_MIN},
                             $urandom(), '0, '0, '0, 64'd7));
        send_packet(make_pkt(CLASS_IPV4, KEY_PROTOCOL, KEY_LEN_PLAIN, {PTP_PREFIX, PTP_LO_MAX},
                             '0, 64'h5555_5555_5555_5555, 64'h0000_0001_0000_0000,
                             64'h0000_0001_0000_0100, 64'd11));
        send_packet(make_pkt(CLASS_IPV4, 8'd17, 16'd90, {PTP_PREFIX, 8'd128},
                             footer_for_tick(31'd200), '0, '0, '0, rand64()));
        send_packet(make_pkt(CLASS_IPV4, 8'd17, 16'd90, {PTP_PREFIX, 8'd133},
                             footer_for_tick(31'd300), '0, '0, '0, rand64()));
        // PTP with zero capture falls to the tick path
        send_packet(make_pkt(CLASS_IPV4, 8'd17, 16'd90, {PTP_PREFIX, 8'd130},
                             footer_for_tick(31'd400), '0, '0, '0, '0));
        // STP, with and without a capture time
        send_packet(make_pkt(CLASS_STP, KEY_PROTOCOL, KEY_LEN_PLAIN, '0, $urandom(),
                             rand64(), rand64(), rand64(), 64'd9));
        send_packet(make_pkt(CLASS_STP, 8'd0, '0, '0, footer_for_tick(31'd500),
                             '0, '0, '0, '0));
        // class 3 and class 0 are never keyframes
        send_packet(make_pkt(2'd3, KEY_PROTOCOL, KEY_LEN_PLAIN, '0, $urandom(),
                             rand64(), rand64(), rand64(), rand64()));
        send_packet(make_pkt(2'd0, KEY_PROTOCOL, KEY_LEN_SKEW, '0, $urandom(),
                             rand64(), rand64(), rand64(), rand64()));
        // keyframe whose own timestamp wraps to zero
        send_packet(make_pkt(CLASS_IPV4, KEY_PROTOCOL, KEY_LEN_PLAIN, 32'h0A00_0005, '0,
                             64'hFFFF_FFFF_FFFF_FFEC, 64'h0000_0033_8000_0010,
                             64'h0000_0033_8000_0017, rand64()));
        // keyframe with zero UTC clears the reference
        send_packet(make_pkt(CLASS_IPV4, KEY_PROTOCOL, KEY_LEN_SKEW, 32'h0A00_0006, '0,
                             '0, rand64(), rand64(), 64'd13));
        send_packet(make_pkt(CLASS_IPV4, 8'd6, 16'd60, 32'h0A00_0007, $urandom(),
                             '0, '0, '0, rand64()));
        // fresh reference for the random traffic
        send_packet(make_pkt(CLASS_IPV4, KEY_PROTOCOL, KEY_LEN_PLAIN, 32'h0A00_0008, '0,
                             64'h1700_0000_0000_0000, 64'h0000_0000_7FFF_F000,
                             64'h0000_0000_8000_0100, rand64()));
        aim_low = 31'h7FFF_F000;
        wait_drained();

        for (int n = 0; n < RANDOM_PACKETS; n++)
        begin
            // one full drain part way through
            if (n == 1200)
                wait_drained();
            send_packet(random_packet());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Result side: pop pattern changes per segment, one long hold-off
    initial
    begin : receiver
        pop_mode_t mode;
        int        seg_left;
        int        hold_left;
        int        popped;
        bit        hold_done;
        mode      = POP_ALWAYS;
        seg_left  = 0;
        hold_left = 0;
        popped    = 0;
        hold_done = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (pop && !empty)
                popped++;
            if (!hold_done && popped >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (seg_left == 0)
            begin
                mode     = pop_mode_t'($urandom_range(0, 3));
                seg_left = $urandom_range(16, 96);
            end
            seg_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                case (mode)
                    POP_ALWAYS: pop <= 1'b1;
                    POP_HALF:   pop <= 1'($urandom_range(0, 1));
                    POP_MOSTLY: pop <= ($urandom_range(0, 3) != 0);
                    default:    pop <= ($urandom_range(0, 3) == 0);
                endcase
            end
            @(posedge clk);
        end
    end

    // Ends the run when neither side moves for too long
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                idle = 0;
            else
                idle++;
        end
        $display("FAILURE");
        $finish;
    end

endmodule
